// ----- rtl/pprg_pkg.sv -----
// Shared constants, types and result codes for the priority preemptive resource grant block.
`default_nettype none

package pprg_pkg;

  localparam int MAX_SLOTS     = 16;
  localparam int NUM_RESOURCES = 32;

  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int RES_W    = 32;
  localparam int STATUS_W = 2;
  localparam int EVICT_W  = 16;
  localparam int GRANT_W  = 4;
  localparam int COUNT_W  = 5;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int EXT_W  = (MAX_SLOTS > EVICT_W) ? MAX_SLOTS : EVICT_W;

  // Resource bits at or above NUM_RESOURCES are dropped from every request.
  localparam logic [RES_W-1:0] RES_LIMIT = (NUM_RESOURCES >= RES_W) ? {RES_W{1'b1}} :
      RES_W'((64'd1 << NUM_RESOURCES) - 64'd1);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACTIVATED = 2'd0,
    STATUS_REJ_PRIO  = 2'd1,
    STATUS_REJ_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [RES_W-1:0]  res;
  } slot_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t             status;
    logic [EVICT_W-1:0]  evicted;
    logic [GRANT_W-1:0]  granted;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/priority_preemptive_resource_grant.sv -----
// Top level of the priority preemptive resource grant block.
//
//  channel   signals                                         direction
//  request   in_valid, in_stall, comm_id, priority_req,      in (in_stall out)
//            resource_mask
//  result    out_valid, out_stall, status, evicted_slots,    out (out_stall in)
//            granted_slot, active_count
//
// A request is handled in steps: capture it, read the slot memory one entry a
// cycle through its single read port, let the last read land, then decide and
// write back.
// Reset (synchronous, active high) clears the slot valid bits and the active
// count; the slot memory itself is not cleared.
// The result sits in an output register, so a new request is taken while an
// earlier result waits; a stalled result holds the decision step, and only
// that step, until the register frees.
`default_nettype none

module priority_preemptive_resource_grant (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pprg_pkg::ID_W-1:0]     comm_id,
  input  logic [pprg_pkg::PRIO_W-1:0]   priority_req,
  input  logic [pprg_pkg::RES_W-1:0]    resource_mask,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pprg_pkg::STATUS_W-1:0] status,
  output logic [pprg_pkg::EVICT_W-1:0]  evicted_slots,
  output logic [pprg_pkg::GRANT_W-1:0]  granted_slot,
  output logic [pprg_pkg::COUNT_W-1:0]  active_count
);
  import pprg_pkg::*;

  mem_req_t    mem_req;
  slot_entry_t rd_data;
  logic        res_valid;
  logic        res_ready;
  result_t     res;
  result_t     out_reg;

  // Slot entries: id, priority and resource mask for each slot.
  pprg_slot_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Sequencer owns the valid bits, the scan and the eviction decision.
  pprg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .comm_id       (comm_id),
    .priority_req  (priority_req),
    .resource_mask (resource_mask),
    .mem_req       (mem_req),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // Output register free when empty or being drained this cycle.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // Load the transaction payload only when it is accepted into the register.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign status        = out_reg.status;
  assign evicted_slots = out_reg.evicted;
  assign granted_slot  = out_reg.granted;
  assign active_count  = out_reg.count;

endmodule

`default_nettype wire

// ----- rtl/pprg_slot_mem.sv -----
// Slot table memory: one write port, one read port, registered read data.
`default_nettype none

module pprg_slot_mem (
  input  logic                clk,
  input  pprg_pkg::mem_req_t  req,
  output pprg_pkg::slot_entry_t rd_data
);
  import pprg_pkg::*;

  slot_entry_t mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pprg_ctrl.sv -----
// Scan sequencer: walks the slot table, gathers conflicts and commits the grant.
`default_nettype none

module pprg_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pprg_pkg::ID_W-1:0]    comm_id,
  input  logic [pprg_pkg::PRIO_W-1:0]  priority_req,
  input  logic [pprg_pkg::RES_W-1:0]   resource_mask,
  output pprg_pkg::mem_req_t           mem_req,
  input  pprg_pkg::slot_entry_t        rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output pprg_pkg::result_t            res
);
  import pprg_pkg::*;

  state_t state, state_next;

  logic [ID_W-1:0]      req_id;
  logic [PRIO_W-1:0]    req_prio;
  logic [RES_W-1:0]     req_mask;
  logic [SLOT_W-1:0]    idx;
  logic                 rd_pend;
  logic [SLOT_W-1:0]    rd_idx;
  logic [MAX_SLOTS-1:0] slot_valid;
  logic [MAX_SLOTS-1:0] slot_valid_next;
  logic [MAX_SLOTS-1:0] conflict;
  logic                 blocked;
  logic [CNT_W-1:0]     conf_cnt;
  logic [CNT_W-1:0]     count;

  logic                 accept;
  logic                 last_idx;
  logic                 hit;
  logic [MAX_SLOTS-1:0] free_vec;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  logic                 grant;
  logic                 commit;
  logic [EXT_W-1:0]     conflict_ext;

  assign accept   = (state == ST_IDLE) && in_valid;
  assign last_idx = (idx == SLOT_W'(MAX_SLOTS - 1));
  assign hit      = rd_pend && slot_valid[rd_idx] && ((rd_data.res & req_mask) != '0);

  // Lowest slot that is empty or would be freed by eviction.
  always_comb begin
    free_vec   = ~slot_valid | conflict;
    free_found = |free_vec;
    free_idx   = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign grant        = !blocked && free_found;
  assign commit       = (state == ST_DECIDE) && res_ready;
  assign conflict_ext = EXT_W'(conflict);

  // Drop the evicted slots, then mark the granted one.
  always_comb begin
    slot_valid_next           = slot_valid & ~conflict;
    slot_valid_next[free_idx] = 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (last_idx) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall          = (state != ST_IDLE);
    res_valid         = (state == ST_DECIDE);
    mem_req.rd_en     = (state == ST_SCAN);
    mem_req.rd_addr   = idx;
    mem_req.wr_en     = commit && grant;
    mem_req.wr_addr   = free_idx;
    mem_req.wr_data   = '{id: req_id, prio: req_prio, res: req_mask};
    res.status        = blocked ? STATUS_REJ_PRIO :
                        (!free_found ? STATUS_REJ_FULL : STATUS_ACTIVATED);
    res.evicted       = grant ? conflict_ext[EVICT_W-1:0] : '0;
    res.granted       = grant ? GRANT_W'(free_idx) : '0;
    res.count         = grant ? COUNT_W'(count - conf_cnt + CNT_W'(1)) : COUNT_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      count      <= '0;
      rd_pend    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
      if (commit && grant) begin
        slot_valid <= slot_valid_next;
        count      <= count - conf_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (accept) begin
      req_id   <= comm_id;
      req_prio <= priority_req;
      req_mask <= resource_mask & RES_LIMIT;
      idx      <= '0;
      conflict <= '0;
      blocked  <= 1'b0;
      conf_cnt <= '0;
    end else begin
      if (state == ST_SCAN && !last_idx) begin
        idx <= idx + SLOT_W'(1);
      end
      if (hit) begin
        conflict[rd_idx] <= 1'b1;
        conf_cnt         <= conf_cnt + CNT_W'(1);
        if (rd_data.prio < req_prio) begin
          blocked <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pprg_checker.sv -----
// Port-level assertions for the grant block, bound to the top level.
`default_nettype none

module pprg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [pprg_pkg::ID_W-1:0]     comm_id,
  input logic [pprg_pkg::PRIO_W-1:0]   priority_req,
  input logic [pprg_pkg::RES_W-1:0]    resource_mask,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pprg_pkg::STATUS_W-1:0] status,
  input logic [pprg_pkg::EVICT_W-1:0]  evicted_slots,
  input logic [pprg_pkg::GRANT_W-1:0]  granted_slot,
  input logic [pprg_pkg::COUNT_W-1:0]  active_count
);
  import pprg_pkg::*;

  // A stalled request holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(comm_id) && $stable(priority_req)
      && $stable(resource_mask))
    else $error("stalled request changed");

  // A stalled result holds its status and active count.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(active_count))
    else $error("stalled result changed");

  // A rejected request neither evicts nor grants.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_REJ_PRIO || status == STATUS_REJ_FULL)
      |-> evicted_slots == '0 && granted_slot == '0)
    else $error("rejected request shows eviction or grant");

  // Table full only when every slot is occupied.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_REJ_FULL |-> active_count == COUNT_W'(MAX_SLOTS))
    else $error("table full reported with free slots");

  // A request is worked on after it is taken: intake closes after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request intake still open after acceptance");

endmodule

bind priority_preemptive_resource_grant pprg_checker u_pprg_checker (.*);

`default_nettype wire
